// ===== src/rpri_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpri_pkg
// Shared constants, types and helpers for the ray / bounded plane test.
// ----------------------------------------------------------------------------
package rpri_pkg;

    localparam int CoordW  = 32;
    localparam int VecW    = 18;
    localparam int RateW   = 31;
    localparam int SumW    = 53;
    localparam int MagW    = 52;
    localparam int QuotW   = 47;
    localparam int NumRegs = 8;
    localparam int AddrW   = 5;
    localparam int InW     = 216;
    localparam int OutW    = 136;

    localparam logic [1:0] MISS_NONE     = 2'd0;
    localparam logic [1:0] MISS_PARALLEL = 2'd1;
    localparam logic [1:0] MISS_BEHIND   = 2'd2;
    localparam logic [1:0] MISS_OUTSIDE  = 2'd3;

    localparam logic [2:0] REG_NORMAL_X = 3'd0;
    localparam logic [2:0] REG_NORMAL_Y = 3'd1;
    localparam logic [2:0] REG_NORMAL_Z = 3'd2;
    localparam logic [2:0] REG_OFFSET   = 3'd3;
    localparam logic [2:0] REG_LEFT     = 3'd4;
    localparam logic [2:0] REG_RIGHT    = 3'd5;
    localparam logic [2:0] REG_BOTTOM   = 3'd6;
    localparam logic [2:0] REG_TOP      = 3'd7;

    // one stage of the restoring divider plus side data
    typedef struct packed {
        logic              vld;
        logic              dz;
        logic              neg;
        logic              sat;
        logic [MagW:0]     r;
        logic [MagW-1:0]   b;
        logic [MagW-1:0]   a;
        logic [QuotW-1:0]  q;
        logic [CoordW-1:0] px;
        logic [CoordW-1:0] py;
        logic [CoordW-1:0] pz;
        logic [CoordW-1:0] vx;
        logic [CoordW-1:0] vy;
        logic [CoordW-1:0] vz;
    } div_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (x < -64'sh8000_0000)
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

endpackage

// ===== src/ray_plane_rect_intersect.sv =====
`timescale 1ns / 1ps
// the path from input beat to result beat runs mostly through
// the 47-stage restoring divider that produces one quotient bit per stage
// throughput: one beat per cycle, every stage takes a new beat each cycle
// unless a stalled result beat holds the whole pipeline; no beat is lost
// reset (aresetn low, synchronous) clears all valid bits and loads the
// register defaults (normal = +z, everything else zero)
// ----------------------------------------------------------------------------
// ray_plane_rect_intersect
// Pipelined intersection of a moving point with a bounded wall plane, Q16.16.
// ----------------------------------------------------------------------------
module ray_plane_rect_intersect
    import rpri_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // config port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input beats
    input  logic             s_tvalid,
    output logic             s_tready,
    // start_x, start_y, start_z, heading_x, heading_y, heading_z,
    // travel_speed, elapsed_time, zero pad
    input  logic [InW-1:0]   s_tdata,
    // result beats
    output logic             m_tvalid,
    input  logic             m_tready,
    // hit, miss_code, hit_param, point_x, point_y, point_z, zero pad
    output logic [OutW-1:0]  m_tdata
);

    // ---------------- configuration registers ----------------
    logic signed [VecW-1:0]   nrm_reg [3];
    logic signed [CoordW-1:0] off_reg, left_reg, right_reg, bot_reg, top_reg;
    logic [2:0]               widx;

    assign pready = 1'b1;
    assign widx   = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nrm_reg[0] <= '0;
            nrm_reg[1] <= '0;
            nrm_reg[2] <= VecW'(65536);
            off_reg    <= '0;
            left_reg   <= '0;
            right_reg  <= '0;
            bot_reg    <= '0;
            top_reg    <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (widx)
                REG_NORMAL_X: nrm_reg[0] <= pwdata[VecW-1:0];
                REG_NORMAL_Y: nrm_reg[1] <= pwdata[VecW-1:0];
                REG_NORMAL_Z: nrm_reg[2] <= pwdata[VecW-1:0];
                REG_OFFSET:   off_reg    <= pwdata;
                REG_LEFT:     left_reg   <= pwdata;
                REG_RIGHT:    right_reg  <= pwdata;
                REG_BOTTOM:   bot_reg    <= pwdata;
                REG_TOP:      top_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            REG_NORMAL_X: prdata = 32'(nrm_reg[0]);
            REG_NORMAL_Y: prdata = 32'(nrm_reg[1]);
            REG_NORMAL_Z: prdata = 32'(nrm_reg[2]);
            REG_OFFSET:   prdata = off_reg;
            REG_LEFT:     prdata = left_reg;
            REG_RIGHT:    prdata = right_reg;
            REG_BOTTOM:   prdata = bot_reg;
            REG_TOP:      prdata = top_reg;
            default:      prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // whole pipe moves together; it holds only when the result beat waits
    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // unpack input beat
    logic signed [CoordW-1:0] in_p [3];
    logic signed [VecW-1:0]   in_h [3];
    logic [RateW-1:0]         in_spd, in_tim;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_p[i] = s_tdata[32*i +: 32];
            in_h[i] = s_tdata[96 + 18*i +: 18];
        end
        in_spd = s_tdata[150 +: 31];
        in_tim = s_tdata[181 +: 31];
    end

    // stage a: speed*time, normal*start
    logic                     a_vld_reg;
    logic [61:0]              a_prod_reg;
    logic signed [49:0]       a_np_reg [3];
    logic signed [CoordW-1:0] a_p_reg [3];
    logic signed [VecW-1:0]   a_h_reg [3];
    // stage b: saturated scale, numerator sum
    logic                     b_vld_reg;
    logic [30:0]              b_s_reg;
    logic signed [SumW-1:0]   b_num_reg;
    logic signed [CoordW-1:0] b_p_reg [3];
    logic signed [VecW-1:0]   b_h_reg [3];
    // stage c: scale*heading
    logic                     c_vld_reg;
    logic signed [49:0]       c_mv_reg [3];
    logic signed [SumW-1:0]   c_num_reg;
    logic signed [CoordW-1:0] c_p_reg [3];
    // stage d: motion vector
    logic                     d_vld_reg;
    logic signed [CoordW-1:0] d_v_reg [3];
    logic signed [SumW-1:0]   d_num_reg;
    logic signed [CoordW-1:0] d_p_reg [3];
    // stage e: normal*motion
    logic                     e_vld_reg;
    logic signed [49:0]       e_dp_reg [3];
    logic signed [CoordW-1:0] e_v_reg [3];
    logic signed [SumW-1:0]   e_num_reg;
    logic signed [CoordW-1:0] e_p_reg [3];
    // stage f: denominator
    logic                     f_vld_reg;
    logic signed [SumW-1:0]   f_den_reg;
    logic signed [SumW-1:0]   f_num_reg;
    logic signed [CoordW-1:0] f_v_reg [3];
    logic signed [CoordW-1:0] f_p_reg [3];
    // stage g: magnitudes and sign
    logic                     g_vld_reg, g_dz_reg, g_neg_reg;
    logic [MagW-1:0]          g_a_reg, g_b_reg;
    logic signed [CoordW-1:0] g_v_reg [3];
    logic signed [CoordW-1:0] g_p_reg [3];

    logic signed [SumW-1:0] num_next, den_next;
    logic [SumW-1:0]        a_abs, b_abs;

    always_comb begin
        num_next = SumW'(a_np_reg[0]) + SumW'(a_np_reg[1]) + SumW'(a_np_reg[2])
                 + (SumW'(off_reg) <<< 16);
        den_next = SumW'(e_dp_reg[0]) + SumW'(e_dp_reg[1]) + SumW'(e_dp_reg[2]);
        a_abs    = f_num_reg[SumW-1] ? SumW'(-f_num_reg) : SumW'(f_num_reg);
        b_abs    = f_den_reg[SumW-1] ? SumW'(-f_den_reg) : SumW'(f_den_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
        end else if (ce) begin
            a_vld_reg <= s_tvalid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a_prod_reg <= 62'(in_spd) * 62'(in_tim);
            for (int i = 0; i < 3; i++) begin
                a_np_reg[i] <= 50'(nrm_reg[i]) * 50'(in_p[i]);
                a_p_reg[i]  <= in_p[i];
                a_h_reg[i]  <= in_h[i];
            end

            b_s_reg   <= (a_prod_reg[61:47] != '0) ? 31'h7FFF_FFFF : a_prod_reg[46:16];
            b_num_reg <= num_next;
            b_p_reg   <= a_p_reg;
            b_h_reg   <= a_h_reg;

            for (int i = 0; i < 3; i++)
                c_mv_reg[i] <= 50'($signed({1'b0, b_s_reg})) * 50'(b_h_reg[i]);
            c_num_reg <= b_num_reg;
            c_p_reg   <= b_p_reg;

            for (int i = 0; i < 3; i++)
                d_v_reg[i] <= sat32(64'(c_mv_reg[i] >>> 16));
            d_num_reg <= c_num_reg;
            d_p_reg   <= c_p_reg;

            for (int i = 0; i < 3; i++)
                e_dp_reg[i] <= 50'(nrm_reg[i]) * 50'(d_v_reg[i]);
            e_v_reg   <= d_v_reg;
            e_num_reg <= d_num_reg;
            e_p_reg   <= d_p_reg;

            f_den_reg <= den_next;
            f_num_reg <= e_num_reg;
            f_v_reg   <= e_v_reg;
            f_p_reg   <= e_p_reg;

            g_dz_reg  <= (f_den_reg == '0);
            g_neg_reg <= f_num_reg[SumW-1] != f_den_reg[SumW-1];
            g_a_reg   <= a_abs[MagW-1:0];
            g_b_reg   <= b_abs[MagW-1:0];
            g_v_reg   <= f_v_reg;
            g_p_reg   <= f_p_reg;
        end
    end

    // ---------------- divider: one quotient bit per stage ----------------
    // quotient = floor(a * 2^16 / b); integer part at or above 2^31 saturates
    div_t dv_reg [QuotW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg[0].vld <= 1'b0;
        end else if (ce) begin
            dv_reg[0].vld <= g_vld_reg;
        end
        if (ce) begin
            dv_reg[0].dz  <= g_dz_reg;
            dv_reg[0].neg <= g_neg_reg;
            dv_reg[0].sat <= ({31'd0, g_a_reg[MagW-1:31]} >= g_b_reg);
            dv_reg[0].r   <= (MagW+1)'(g_a_reg[MagW-1:31]);
            dv_reg[0].b   <= g_b_reg;
            dv_reg[0].a   <= g_a_reg;
            dv_reg[0].q   <= '0;
            dv_reg[0].px  <= g_p_reg[0];
            dv_reg[0].py  <= g_p_reg[1];
            dv_reg[0].pz  <= g_p_reg[2];
            dv_reg[0].vx  <= g_v_reg[0];
            dv_reg[0].vy  <= g_v_reg[1];
            dv_reg[0].vz  <= g_v_reg[2];
        end
    end

    for (genvar j = 1; j <= QuotW; j++) begin : g_div
        localparam int K = QuotW - j;
        div_t        st;
        logic [MagW+1:0] rs;
        logic        bit_in;

        always_comb begin
            if (K >= 16)
                bit_in = dv_reg[j-1].a[(K >= 16) ? K - 16 : 0];
            else
                bit_in = 1'b0;
            rs = {dv_reg[j-1].r, bit_in};
            st = dv_reg[j-1];
            if (rs >= {1'b0, 1'b0, dv_reg[j-1].b}) begin
                st.r    = (MagW+1)'(rs - {2'b00, dv_reg[j-1].b});
                st.q[K] = 1'b1;
            end else begin
                st.r    = rs[MagW:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j].vld <= 1'b0;
            end else if (ce) begin
                dv_reg[j] <= st;
            end
        end
    end

    // ---------------- t, point, bounds ----------------
    div_t last;
    assign last = dv_reg[QuotW];

    logic signed [31:0] t_next;
    always_comb begin
        if (last.dz)
            t_next = '0;
        else if (last.neg)
            t_next = (last.sat || last.q > QuotW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                                 : last.q[31:0];
        else
            t_next = (last.sat || last.q > QuotW'(33'h1_0000_0000 >> 1)) ?
                     32'sh8000_0000 : 32'(-$signed({1'b0, last.q}));
    end

    // stage t
    logic                     t_vld_reg, t_dz_reg;
    logic signed [31:0]       t_t_reg;
    logic signed [CoordW-1:0] t_p_reg [3];
    logic signed [CoordW-1:0] t_v_reg [3];
    // stage u: t*v
    logic                     u_vld_reg, u_dz_reg;
    logic signed [31:0]       u_t_reg;
    logic signed [63:0]       u_tv_reg [3];
    logic signed [CoordW-1:0] u_p_reg [3];
    // stage w: point
    logic                     w_vld_reg, w_dz_reg;
    logic signed [31:0]       w_t_reg;
    logic signed [CoordW-1:0] w_pt_reg [3];

    // output register
    logic               m_vld_reg, hit_reg;
    logic [1:0]         code_reg;
    logic signed [31:0] t_out_reg;
    logic signed [31:0] pt_out_reg [3];

    logic [1:0] code_next;
    logic       in_bounds;
    always_comb begin
        in_bounds = w_pt_reg[0] >= left_reg && w_pt_reg[0] <= right_reg &&
                    w_pt_reg[1] >= bot_reg  && w_pt_reg[1] <= top_reg;
        if (w_dz_reg)
            code_next = MISS_PARALLEL;
        else if (w_t_reg <= 0)
            code_next = MISS_BEHIND;
        else if (in_bounds)
            code_next = MISS_NONE;
        else
            code_next = MISS_OUTSIDE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_vld_reg <= 1'b0;
            u_vld_reg <= 1'b0;
            w_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
        end else if (ce) begin
            t_vld_reg <= last.vld;
            u_vld_reg <= t_vld_reg;
            w_vld_reg <= u_vld_reg;
            m_vld_reg <= w_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            t_dz_reg   <= last.dz;
            t_t_reg    <= t_next;
            t_p_reg[0] <= last.px;
            t_p_reg[1] <= last.py;
            t_p_reg[2] <= last.pz;
            t_v_reg[0] <= last.vx;
            t_v_reg[1] <= last.vy;
            t_v_reg[2] <= last.vz;

            u_dz_reg <= t_dz_reg;
            u_t_reg  <= t_t_reg;
            u_p_reg  <= t_p_reg;
            for (int i = 0; i < 3; i++)
                u_tv_reg[i] <= 64'(t_t_reg) * 64'(t_v_reg[i]);

            w_dz_reg <= u_dz_reg;
            w_t_reg  <= u_t_reg;
            for (int i = 0; i < 3; i++)
                w_pt_reg[i] <= (u_dz_reg || u_t_reg <= 0) ? 32'sd0 :
                               sat32(64'(u_p_reg[i]) + (u_tv_reg[i] >>> 16));

            hit_reg    <= (code_next == MISS_NONE);
            code_reg   <= code_next;
            t_out_reg  <= w_t_reg;
            pt_out_reg <= w_pt_reg;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {5'd0, pt_out_reg[2], pt_out_reg[1], pt_out_reg[0],
                       t_out_reg, code_reg, hit_reg};

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ray_plane_rect_intersect: plane and rectangle
// registers are set over the config port in several phases, and each phase
// streams random rays (the first two also directed ones) with random idle
// gaps on both streams. Every result beat is checked against a bit-exact
// Q16.16 intersection predictor kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb
    import rpri_pkg::*;
();

    localparam longint MaxS32 = 64'sh7FFF_FFFF;
    localparam longint MinS32 = -64'sh8000_0000;
    localparam int     One    = 65536;

    typedef struct {
        logic signed [31:0] sx, sy, sz;
        logic signed [17:0] hx, hy, hz;
        logic        [30:0] spd, tim;
    } ray_t;

    typedef struct packed {
        logic               hit;
        logic        [1:0]  code;
        logic signed [31:0] t, px, py, pz;
    } isect_t;

    // scoreboard: own copy of the wall registers plus the queue of
    // predicted intersections
    class isect_scoreboard;
        longint wall[NumRegs];
        isect_t pending[$];
        int     errors;
        int     checked;
        int     code_cnt[4];

        function new();
            wall = '{0, 0, One, 0, 0, 0, 0, 0};
        endfunction

        function void set_reg(int idx, logic [31:0] val);
            if (idx < 3)
                wall[idx] = longint'($signed(val[17:0]));
            else
                wall[idx] = longint'($signed(val));
        endfunction

        function longint clip32(longint x);
            if (x > MaxS32) return MaxS32;
            if (x < MinS32) return MinS32;
            return x;
        endfunction

        // t = -num/den in Q16.16, magnitude truncated, saturated
        function longint div_q16(longint num, longint den);
            bit neg;
            longint unsigned a, b, q, r;
            neg = (num < 0) != (den < 0);
            a = (num < 0) ? -num : num;
            b = (den < 0) ? -den : den;
            q = a / b;
            r = a % b;
            if (q >= 64'h8000_0000)
                return neg ? MaxS32 : MinS32;
            for (int i = 0; i < 16; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= b) begin
                    r = r - b;
                    q = q | 1;
                end
            end
            if (neg)
                return (q > 64'h7FFF_FFFF) ? MaxS32 : longint'(q);
            return (q > 64'h8000_0000) ? MinS32 : -longint'(q);
        endfunction

        function isect_t predict(ray_t r);
            longint p[3], h[3], v[3], pt[3];
            longint s, den, num, t;
            longint unsigned prod, spd;
            isect_t e;
            p = '{r.sx, r.sy, r.sz};
            h = '{r.hx, r.hy, r.hz};
            pt = '{0, 0, 0};
            spd = r.spd;
            prod = (spd * r.tim) >> 16;
            s = (prod > 64'h7FFF_FFFF) ? MaxS32 : longint'(prod);
            den = 0;
            num = 0;
            t = 0;
            for (int i = 0; i < 3; i++) begin
                v[i] = clip32((s * h[i]) >>> 16);
                den += wall[i] * v[i];
                num += wall[i] * p[i];
            end
            num += wall[3] * One;
            e.hit = 0;
            if (den == 0) begin
                e.code = MISS_PARALLEL;
            end else begin
                t = div_q16(num, den);
                if (t <= 0) begin
                    e.code = MISS_BEHIND;
                end else begin
                    for (int i = 0; i < 3; i++)
                        pt[i] = clip32(p[i] + ((t * v[i]) >>> 16));
                    if (pt[0] >= wall[4] && pt[0] <= wall[5] &&
                        pt[1] >= wall[6] && pt[1] <= wall[7]) begin
                        e.hit = 1;
                        e.code = MISS_NONE;
                    end else begin
                        e.code = MISS_OUTSIDE;
                    end
                end
            end
            e.t = t[31:0];
            e.px = pt[0][31:0];
            e.py = pt[1][31:0];
            e.pz = pt[2][31:0];
            return e;
        endfunction

        function void note(ray_t r);
            pending = {pending, predict(r)};
        endfunction

        function void check(isect_t got);
            isect_t e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: hit=%0d code=%0d t=%0d",
                             got.hit, got.code, got.t);
                return;
            end
            e = pending.pop_front();
            checked++;
            code_cnt[e.code]++;
            if (got !== e) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch #%0d: exp hit=%0d code=%0d t=%0d pt=(%0d,%0d,%0d)",
                              " got hit=%0d code=%0d t=%0d pt=(%0d,%0d,%0d)"},
                             checked, e.hit, e.code, e.t, e.px, e.py, e.pz,
                             got.hit, got.code, got.t, got.px, got.py, got.pz);
            end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // start_x, start_y, start_z, heading_x, heading_y, heading_z,
    // travel_speed, elapsed_time, zero pad
    logic [InW-1:0]   s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // hit, miss_code, hit_param, point_x, point_y, point_z, zero pad
    logic [OutW-1:0]  m_tdata;

    isect_scoreboard sb = new();
    bit              no_idle = 1'b0;   // stretches with back-to-back beats
    int              sink_stall = 0;
    int              beat_cnt = 0;
    int              seen_cnt = 0;

    always #5 aclk = ~aclk;

    ray_plane_rect_intersect u_top (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .pready, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
    );

    // result sink: new stall draw after each beat, applied on the falling edge
    always @(negedge aclk) begin
        if (beat_cnt != seen_cnt) begin
            seen_cnt = beat_cnt;
            sink_stall = no_idle ? 0 : $urandom_range(0, 9);
        end
        if (sink_stall > 0) begin
            m_tready <= 1'b0;
            sink_stall = sink_stall - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            isect_t got;
            got.hit  = m_tdata[0];
            got.code = m_tdata[2:1];
            got.t    = m_tdata[34:3];
            got.px   = m_tdata[66:35];
            got.py   = m_tdata[98:67];
            got.pz   = m_tdata[130:99];
            sb.check(got);
            beat_cnt <= beat_cnt + 1;
        end
    end

    // register write: setup then access cycle
    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = AddrW'(idx) << 2;
        pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        sb.set_reg(idx, val);
    endtask

    // wait until every predicted beat came back, then let the pipe drain
    task automatic drain();
        while (sb.pending.size() != 0)
            @(negedge aclk);
        repeat (70) @(negedge aclk);
    endtask

    task automatic set_wall(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                            logic [31:0] d, logic [31:0] l, logic [31:0] r,
                            logic [31:0] b, logic [31:0] t);
        drain();
        cfg_write(REG_NORMAL_X, nx);
        cfg_write(REG_NORMAL_Y, ny);
        cfg_write(REG_NORMAL_Z, nz);
        cfg_write(REG_OFFSET, d);
        cfg_write(REG_LEFT, l);
        cfg_write(REG_RIGHT, r);
        cfg_write(REG_BOTTOM, b);
        cfg_write(REG_TOP, t);
    endtask

    // one input beat; called and returns just after a falling edge
    task automatic send_ray(ray_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = '0;
        s_tdata[211:0] = {r.tim, r.spd, r.hz, r.hy, r.hx, r.sz, r.sy, r.sx};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note(r);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    function automatic ray_t mk(int x, int y, int z, int hx, int hy, int hz,
                                int spd, int tim);
        ray_t r;
        r.sx = x; r.sy = y; r.sz = z;
        r.hx = 18'(hx); r.hy = 18'(hy); r.hz = 18'(hz);
        r.spd = 31'(spd); r.tim = 31'(tim);
        return r;
    endfunction

    function automatic logic [17:0] edge_heading();
        case ($urandom_range(0, 4))
            0: return 18'd0;
            1: return 18'd65536;
            2: return -18'sd65536;
            3: return 18'h20000;
            default: return 18'h1FFFF;
        endcase
    endfunction

    // mostly rays aimed near the wall with random content, some raw noise
    // and some field extremes
    function automatic ray_t rand_ray();
        ray_t r;
        int   sel, span;
        sel = $urandom_range(0, 99);
        span = 200 * One;
        if (sel < 78) begin
            r.sx = $urandom_range(0, 2 * span) - span;
            r.sy = $urandom_range(0, 2 * span) - span;
            r.sz = $urandom_range(0, 2 * span) - span;
            r.hx = 18'($urandom_range(0, 2 * One) - One);
            r.hy = 18'($urandom_range(0, 2 * One) - One);
            r.hz = 18'($urandom_range(0, 2 * One) - One);
            r.spd = 31'($urandom_range(0, 30 * One));
            r.tim = 31'($urandom_range(0, 4 * One));
        end else if (sel < 93) begin
            r.sx = $urandom; r.sy = $urandom; r.sz = $urandom;
            r.hx = 18'($urandom); r.hy = 18'($urandom); r.hz = 18'($urandom);
            r.spd = 31'($urandom); r.tim = 31'($urandom);
        end else begin
            r.sx = ($urandom_range(0, 1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            r.sy = ($urandom_range(0, 1)) ? 32'h8000_0000 : $urandom;
            r.sz = ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'd0;
            r.hx = edge_heading();
            r.hy = edge_heading();
            r.hz = edge_heading();
            r.spd = ($urandom_range(0, 1)) ? 31'h7FFF_FFFF : 31'($urandom);
            r.tim = ($urandom_range(0, 1)) ? 31'h7FFF_FFFF : 31'd0;
        end
        return r;
    endfunction

    task automatic random_rays(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 60 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            send_ray(rand_ray());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // defaults after reset: plane z = 0, degenerate rectangle at origin
        send_ray(mk(0, 0, -One, 0, 0, One, One, One));
        random_rays(150);

        // plane z = 10, rectangle +-50 square
        set_wall(0, 0, One, -10 * One, -50 * One, 50 * One, -50 * One, 50 * One);
        send_ray(mk(0, 0, 0, 0, 0, One, One, 20 * One));              // hit
        send_ray(mk(0, 0, 0, One, 0, 0, One, 20 * One));              // parallel
        send_ray(mk(0, 0, 0, 0, 0, -One, One, 20 * One));             // behind
        send_ray(mk(100 * One, 0, 0, 0, 0, One, One, 20 * One));      // outside
        send_ray(mk(50 * One, -50 * One, 0, 0, 0, One, One, One));    // on corner
        send_ray(mk(0, 0, 0, 0, 0, One, 0, 20 * One));                // no speed
        send_ray(mk(0, 0, 0, 0, 0, One, 20 * One, 0));                // no time
        send_ray(mk(0, 0, 10 * One, 0, 0, One, One, One));            // starts on wall
        send_ray(mk(0, 0, 0, 0, 0, One, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_ray(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    18'h20000, 18'h20000, 18'h20000, 1, 1));
        send_ray(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_ray(mk(0, 0, 32'h8000_0000, 0, 0, One, One, 1));         // t saturates
        send_ray(mk(30 * One, 0, 0, One, 0, One, One, 20 * One));     // oblique
        send_ray(mk(-40 * One, 40 * One, 20 * One, 0, 0, -One, One, One));
        random_rays(200);

        // sender holds off until the pipe is empty, then continues
        drain();
        random_rays(150);

        // wall facing -x, inverted rectangle: never a hit
        set_wall(-One, 0, 0, 25 * One, 60 * One, -60 * One, 60 * One, -60 * One);
        random_rays(250);

        // register extremes, out-of-range normal bit patterns
        set_wall(32'h0002_0000, 32'h0001_FFFF, 32'h0002_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        random_rays(250);
        set_wall(One, One, One, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF);
        random_rays(200);

        // oblique random wall with a wide rectangle
        set_wall($urandom_range(0, 2 * One) - One, $urandom_range(0, 2 * One) - One,
                 $urandom_range(0, 2 * One) - One, $urandom_range(0, 100 * One) - 50 * One,
                 -150 * One, 150 * One, -150 * One, 150 * One);
        random_rays(270);

        // ceiling facing -y, narrow rectangle
        set_wall(0, -One, 0, 40 * One, -20 * One, 20 * One, -300 * One, 300 * One);
        random_rays(260);

        s_tvalid = 1'b0;
        drain();
        $display("rays checked: %0d  hits: %0d  parallel: %0d  behind: %0d  outside: %0d",
                 sb.checked, sb.code_cnt[MISS_NONE], sb.code_cnt[MISS_PARALLEL],
                 sb.code_cnt[MISS_BEHIND], sb.code_cnt[MISS_OUTSIDE]);
        $display("seven wall settings incl. reset defaults and register extremes");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("mismatches: %0d  left over: %0d", sb.errors, sb.pending.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/rpri_pkg.sv
src/ray_plane_rect_intersect.sv
bench/tb.sv
